// ===== design/ptq_pkg.sv =====
// Shared types and constants for the two-queue strict-priority transmit queue.
package ptq_pkg;

  localparam int HANDLE_W = 16;
  localparam int CAP_W    = 7;
  localparam int LEN_W    = 7;
  localparam int DROP_W   = 32;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_MGMT_OVF = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

endpackage

// ===== design/priority_two_queue_tail_drop.sv =====
// Top level of the strict-priority transmit queue with tail drop on data frames.
// Each request is either an enqueue or a dequeue and produces exactly one result.
// Management descriptors go to the management FIFO, and an enqueue to a full
// management FIFO reports an overflow. Data descriptors go to the data FIFO
// unless its occupancy has reached data_capacity (zero, or any value above
// DATA_DEPTH, means DATA_DEPTH), in which case they are dropped and counted in a
// saturating counter. A dequeue serves management first, then data. The block
// takes one request per clock cycle; its result appears in the output register
// on the next cycle, with the dequeued descriptor taken from the registered read
// port of the FIFO memory. While a result waits under stall, no new request is
// taken. Write data_capacity only while the block is idle.
module priority_two_queue_tail_drop #(
  parameter int DATA_DEPTH = 64,
  parameter int MGMT_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptq_pkg::CAP_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic                            is_data_i,
  input  logic [ptq_pkg::HANDLE_W-1:0]    frame_handle_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [ptq_pkg::HANDLE_W-1:0]    handle_out_o,
  output logic                            from_mgmt_o,
  output logic [ptq_pkg::LEN_W-1:0]       data_length_o,
  output logic [ptq_pkg::DROP_W-1:0]      data_drop_count_o
);
  import ptq_pkg::*;

  localparam int DCNT_W = $clog2(DATA_DEPTH + 1);
  localparam int MCNT_W = $clog2(MGMT_DEPTH + 1);
  localparam int LIM_W  = (DCNT_W > CAP_W) ? DCNT_W : CAP_W;

  logic [CAP_W-1:0]    capacity_q;
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic                from_mgmt_q, from_mgmt_d;
  logic [DROP_W-1:0]   drop_q, drop_d;

  fifo_req_t           data_req, mgmt_req;
  logic [HANDLE_W-1:0] data_rdata, mgmt_rdata;
  logic [DCNT_W-1:0]   data_count;
  logic [MCNT_W-1:0]   mgmt_count;

  logic                accept;
  logic [LIM_W-1:0]    limit;
  logic                data_full, mgmt_full;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign limit = (capacity_q == '0 || LIM_W'(capacity_q) > LIM_W'(DATA_DEPTH))
               ? LIM_W'(DATA_DEPTH) : LIM_W'(capacity_q);
  assign data_full = LIM_W'(data_count) >= limit;
  assign mgmt_full = mgmt_count == MCNT_W'(MGMT_DEPTH);

  always_comb begin
    data_req    = '0;
    mgmt_req    = '0;
    status_d    = status_q;
    from_mgmt_d = from_mgmt_q;
    drop_d      = drop_q;
    if (accept) begin
      from_mgmt_d = 1'b0;
      if (op_i == OP_ENQ) begin
        if (!is_data_i) begin
          if (mgmt_full) begin
            status_d = ST_MGMT_OVF;
          end else begin
            mgmt_req.push = 1'b1;
            status_d      = ST_QUEUED;
          end
        end else if (data_full) begin
          status_d = ST_DROPPED;
          if (drop_q != '1) begin
            drop_d = drop_q + 1'b1;
          end
        end else begin
          data_req.push = 1'b1;
          status_d      = ST_QUEUED;
        end
      end else begin
        if (mgmt_count != '0) begin
          mgmt_req.pop = 1'b1;
          from_mgmt_d  = 1'b1;
          status_d     = ST_DEQUEUED;
        end else if (data_count != '0) begin
          data_req.pop = 1'b1;
          status_d     = ST_DEQUEUED;
        end else begin
          status_d = ST_EMPTY;
        end
      end
    end
  end

  ptq_fifo #(
    .DEPTH (DATA_DEPTH)
  ) u_data_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (data_req),
    .wdata_i (frame_handle_i),
    .rdata_o (data_rdata),
    .count_o (data_count)
  );

  ptq_fifo #(
    .DEPTH (MGMT_DEPTH)
  ) u_mgmt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mgmt_req),
    .wdata_i (frame_handle_i),
    .rdata_o (mgmt_rdata),
    .count_o (mgmt_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_EMPTY;
      from_mgmt_q <= 1'b0;
      drop_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      status_q    <= status_d;
      from_mgmt_q <= from_mgmt_d;
      drop_q      <= drop_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign from_mgmt_o       = from_mgmt_q;
  assign handle_out_o      = (status_q != ST_DEQUEUED) ? '0
                           : (from_mgmt_q ? mgmt_rdata : data_rdata);
  assign data_length_o     = LEN_W'(data_count);
  assign data_drop_count_o = drop_q;

endmodule

// ===== design/ptq_fifo.sv =====
// Descriptor FIFO with a memory store, registered read data and an occupancy count.
module ptq_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptq_pkg::fifo_req_t                req_i,
  input  logic [ptq_pkg::HANDLE_W-1:0]      wdata_i,
  output logic [ptq_pkg::HANDLE_W-1:0]      rdata_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);
  import ptq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [HANDLE_W-1:0] mem [DEPTH];
  logic [HANDLE_W-1:0] rdata_q;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (req_i.pop) begin
      head_d = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    case ({req_i.push, req_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= wdata_i;
    end
    if (req_i.pop) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

endmodule

// ===== design/ptq_checker.sv =====
// Port-level checker for the strict-priority transmit queue, bound to the top level.
module ptq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [2:0]                      status_o,
  input logic [ptq_pkg::HANDLE_W-1:0]    handle_out_o,
  input logic                            from_mgmt_o,
  input logic [ptq_pkg::LEN_W-1:0]       data_length_o,
  input logic [ptq_pkg::DROP_W-1:0]      data_drop_count_o
);
  import ptq_pkg::*;

  // A result held under stall keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(handle_out_o) && $stable(from_mgmt_o))
    else $error("result changed while stalled");

  // Only a dequeue carries a descriptor or a management source.
  a_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DEQUEUED |-> handle_out_o == '0 && !from_mgmt_o)
    else $error("descriptor reported without a dequeue");

  // A tail drop happens only when the data queue holds frames.
  a_drop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DROPPED |-> data_length_o != '0)
    else $error("drop reported with an empty data queue");

  // The drop counter never goes down.
  a_drop_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> data_drop_count_o >= $past(data_drop_count_o))
    else $error("drop counter decreased");

endmodule

bind priority_two_queue_tail_drop ptq_checker u_ptq_checker (.*);
